### design/bbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the bitcode block size scanner.
// ----------------------------------------------------------------------------
package bbs_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'hDEC0_4342;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [31:0] data_word;
		logic        first_word;
	} word_t;

	typedef struct packed {
		logic [31:0] used_bytes;
		logic [2:0]  stop_reason;
	} result_t;

	// word after front-end classification
	typedef struct packed {
		logic [31:0] data_word;
		logic        first_word;
		logic        is_magic;
		logic        is_zero;
		logic        vbr_end;    // a chunk without continue bit exists
		logic        vbr_nz;     // nonzero data bits up to and including the end chunk
	} cls_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_BLOCK  = 3'd1,
		PH_VBR    = 3'd2,
		PH_LENGTH = 3'd3,
		PH_SKIP   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	localparam logic [2:0] RSN_NOT_BC   = 3'd0;
	localparam logic [2:0] RSN_MAGIC    = 3'd1;
	localparam logic [2:0] RSN_ZERO_VBR = 3'd2;
	localparam logic [2:0] RSN_ZERO_LEN = 3'd3;
	localparam logic [2:0] RSN_LEN_BIG  = 3'd4;
	localparam logic [2:0] RSN_BUF_END  = 3'd5;

endpackage

### design/bbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_front
// Takes input words and classifies them (magic, zero, VBR chunk scan).
// ----------------------------------------------------------------------------
module bbs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          word_valid,
	output logic          word_stall,
	input  bbs_pkg::word_t word,
	output logic          cls_valid,
	input  logic          cls_ready,
	output bbs_pkg::cls_t cls
);

	bbs_pkg::cls_t cls_c;
	bbs_pkg::cls_t cls_s1;
	logic          valid_s1;
	logic          done_c;
	logic          nz_c;
	logic [3:0]    chunk;

	// chunks are scanned LSB first; only chunks up to the first one
	// without a continue bit count toward the value
	always_comb begin
		done_c = 1'b0;
		nz_c   = 1'b0;
		chunk  = 4'd0;
		for (int k = 0; k < 8; k++) begin
			chunk = word.data_word[4*k +: 4];
			if (!done_c) begin
				if (chunk[2:0] != 3'd0) nz_c = 1'b1;
				if (!chunk[3]) done_c = 1'b1;
			end
		end
		cls_c.data_word  = word.data_word;
		cls_c.first_word = word.first_word;
		cls_c.is_magic   = (word.data_word == bbs_pkg::MAGIC_WORD);
		cls_c.is_zero    = (word.data_word == 32'd0);
		cls_c.vbr_end    = done_c;
		cls_c.vbr_nz     = nz_c;
	end

	assign word_stall = valid_s1 && !cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			cls_s1 <= cls_c;
		end
	end

	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

endmodule

### design/bbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_queue
// Short FIFO of classified words between front and back end.
// ----------------------------------------------------------------------------
module bbs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  bbs_pkg::cls_t wr_data,
	output logic          rd_valid,
	input  logic          rd_pop,
	output bbs_pkg::cls_t rd_data
);

	bbs_pkg::cls_t                mem_q [bbs_pkg::QDEPTH];
	logic [bbs_pkg::QAW-1:0]      wr_ptr_q;
	logic [bbs_pkg::QAW-1:0]      rd_ptr_q;
	logic [bbs_pkg::QAW:0]        count_q;
	logic                         push;
	logic                         pop;

	assign wr_ready = (count_q != (bbs_pkg::QAW+1)'(bbs_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (bbs_pkg::QAW+1)'(bbs_pkg::QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

### design/bbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_back
// Scan sequencer: walks blocks word by word and registers the result.
// ----------------------------------------------------------------------------
module bbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_data,
	input  logic            item_valid,
	output logic            item_pop,
	input  bbs_pkg::cls_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output bbs_pkg::result_t result
);

	bbs_pkg::phase_t  phase_q, phase_d;
	logic [31:0]      offset_q, offset_d;
	logic [31:0]      skip_q, skip_d;
	logic             allz_q, allz_d;
	logic [31:0]      buf_bytes_q;
	logic             out_valid_q;
	bbs_pkg::result_t out_q;

	logic             stop;
	logic [2:0]       rsn;
	logic [31:0]      used;
	logic [31:0]      off_n;
	logic [31:0]      left;
	logic [31:0]      skn;
	logic             az;
	logic             check_end;

	assign item_pop = item_valid && (!out_valid_q || !result_stall);
	assign off_n    = offset_q + 32'd4;
	assign left     = (off_n <= buf_bytes_q) ? (buf_bytes_q - off_n) : 32'd0;
	assign skn      = (skip_q != 32'd0) ? (skip_q - 32'd1) : 32'd0;

	always_comb begin
		phase_d   = phase_q;
		offset_d  = offset_q;
		skip_d    = skip_q;
		allz_d    = allz_q;
		stop      = 1'b0;
		rsn       = bbs_pkg::RSN_NOT_BC;
		used      = 32'd0;
		check_end = 1'b0;
		az        = allz_q;
		if (item.first_word) begin
			skip_d = 32'd0;
			allz_d = 1'b1;
			if (buf_bytes_q < 32'd4 || !item.is_magic) begin
				offset_d = 32'd0;
				stop     = 1'b1;
			end else begin
				offset_d  = 32'd4;
				phase_d   = bbs_pkg::PH_BLOCK;
				check_end = 1'b1;
			end
		end else begin
			unique case (phase_q)
				bbs_pkg::PH_BLOCK, bbs_pkg::PH_VBR: begin
					if (phase_q == bbs_pkg::PH_BLOCK && offset_q > 32'd4 && item.is_magic) begin
						stop = 1'b1;
						rsn  = bbs_pkg::RSN_MAGIC;
						used = offset_q;
					end else begin
						az       = ((phase_q == bbs_pkg::PH_BLOCK) || allz_q) && !item.vbr_nz;
						allz_d   = az;
						offset_d = off_n;
						if (item.vbr_end && az) begin
							stop = 1'b1;
							rsn  = bbs_pkg::RSN_ZERO_VBR;
							used = off_n;
						end else begin
							phase_d   = item.vbr_end ? bbs_pkg::PH_LENGTH : bbs_pkg::PH_VBR;
							check_end = 1'b1;
						end
					end
				end
				bbs_pkg::PH_LENGTH: begin
					offset_d = off_n;
					if (item.is_zero) begin
						stop = 1'b1;
						rsn  = bbs_pkg::RSN_ZERO_LEN;
						used = off_n;
					end else if ({item.data_word, 2'b00} > {2'b00, left}) begin
						stop = 1'b1;
						rsn  = bbs_pkg::RSN_LEN_BIG;
						used = off_n;
					end else begin
						skip_d  = item.data_word;
						phase_d = bbs_pkg::PH_SKIP;
					end
				end
				bbs_pkg::PH_SKIP: begin
					offset_d = off_n;
					skip_d   = skn;
					if (skn == 32'd0) begin
						phase_d   = bbs_pkg::PH_BLOCK;
						check_end = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		// no room for another word: stop right away
		if (check_end && ({1'b0, offset_d} + 33'd4 > {1'b0, buf_bytes_q})) begin
			stop = 1'b1;
			rsn  = bbs_pkg::RSN_BUF_END;
			used = offset_d;
		end
		if (stop) phase_d = bbs_pkg::PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= bbs_pkg::PH_IDLE;
			offset_q    <= 32'd0;
			skip_q      <= 32'd0;
			allz_q      <= 1'b1;
			buf_bytes_q <= 32'd4;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) buf_bytes_q <= cfg_data;
			if (item_pop) begin
				phase_q  <= phase_d;
				offset_q <= offset_d;
				skip_q   <= skip_d;
				allz_q   <= allz_d;
			end
			if (item_pop && stop) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && stop) begin
			out_q.used_bytes  <= used;
			out_q.stop_reason <= rsn;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> phase_q == bbs_pkg::PH_DONE)
		else $error("result raised without scan stop");
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bbs_pkg::PH_SKIP |-> skip_q != 32'd0)
		else $error("skip phase with empty skip count");
	a_idle_offset: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bbs_pkg::PH_IDLE |-> offset_q == 32'd0 && allz_q)
		else $error("idle phase with stale scan state");
`endif

endmodule

### design/bitcode_block_size_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcode_block_size_scanner
// Finds how many bytes of a word stream the wrapped bitcode occupies.
// ----------------------------------------------------------------------------
// Usage:
//  - word channel (word_valid / word_stall / word): one little-endian 32-bit
//    buffer word per transfer; first_word set on the first word of a buffer.
//  - result channel (result_valid / result_stall / result): at most one
//    result per buffer, sent when the scan stops.
//  - cfg channel (cfg_valid / cfg_ready / cfg_data): buffer length in bytes;
//    cfg_ready is always high. Write only while the block is idle.
//  - Throughput: one word per cycle while word_stall is low. A result becomes
//    valid once the word that ends the scan has passed the front register,
//    the queue and the back-end result register.
//  - A four-entry queue decouples the front end from the scan sequencer; the
//    sequencer holds off while a result sits stalled in its output register,
//    and word_stall rises once the queue and front register fill up.
//  - Reset clears the scan to idle and the buffer length to 4; words before
//    a first word or after a stop are dropped without a result.
// ----------------------------------------------------------------------------
module bitcode_block_size_scanner (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid,
	output logic             word_stall,
	input  bbs_pkg::word_t   word,
	output logic             result_valid,
	input  logic             result_stall,
	output bbs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [31:0]      cfg_data
);

	logic          cls_valid;
	logic          cls_ready;
	bbs_pkg::cls_t cls;
	logic          q_valid;
	logic          q_pop;
	bbs_pkg::cls_t q_data;

	assign cfg_ready = 1'b1;

	bbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.cls_valid  (cls_valid),
		.cls_ready  (cls_ready),
		.cls        (cls)
	);

	bbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cls_valid),
		.wr_ready (cls_ready),
		.wr_data  (cls),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_data)
	);

	bbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (q_valid),
		.item_pop     (q_pop),
		.item         (q_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### verif/bitcode_block_size_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcode_block_size_scanner_test
// Streams buffers into the scanner under random idling and stalls and checks
// each stop offset and reason against a scan predictor kept in the bench.
// ----------------------------------------------------------------------------
module bitcode_block_size_scanner_test;

	localparam int ITEM_TARGET   = 1600;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 500000;

	logic             clk;
	logic             arst_n;
	logic             word_valid;
	logic             word_stall;
	bbs_pkg::word_t   word;
	logic             result_valid;
	logic             result_stall;
	bbs_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [31:0]      cfg_data;

	// scan predictor state
	bbs_pkg::phase_t  scan_phase;
	logic [31:0]      scan_offset;
	logic [31:0]      skip_left;
	logic             vbr_zero;
	logic [31:0]      buf_bytes;

	bbs_pkg::result_t pending_results[$];

	bit calm;           // no idling on either side
	int hold_requests;  // bumped to ask the receiver for a long hold
	int words_active;
	int words_ignored;
	int results_seen;
	int settings_used;
	int errors;
	int cycle_count = 0;

	bitcode_block_size_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bitcode_block_size_scanner_test: FAIL");
			$finish;
		end
	end

	function automatic bit halt_scan(input logic [2:0] why, input logic [31:0] at,
			output bbs_pkg::result_t r);
		r.used_bytes  = at;
		r.stop_reason = why;
		scan_phase    = bbs_pkg::PH_DONE;
		return 1'b1;
	endfunction

	// stops at once when the next word would not fit in the buffer
	function automatic bit check_room(output bbs_pkg::result_t r);
		r = '0;
		if ({1'b0, scan_offset} + 33'd4 > {1'b0, buf_bytes})
			return halt_scan(bbs_pkg::RSN_BUF_END, scan_offset, r);
		return 1'b0;
	endfunction

	function automatic bit scan_word(input logic [31:0] d, input logic first,
			output bbs_pkg::result_t r);
		logic [33:0] left;
		logic [3:0]  nib;
		bit          ended;
		int          k;
		r = '0;
		if (first) begin
			skip_left   = '0;
			vbr_zero    = 1'b1;
			scan_offset = '0;
			if (buf_bytes < 32'd4 || d != bbs_pkg::MAGIC_WORD)
				return halt_scan(bbs_pkg::RSN_NOT_BC, 32'd0, r);
			scan_offset = 32'd4;
			scan_phase  = bbs_pkg::PH_BLOCK;
			return check_room(r);
		end
		case (scan_phase)
			bbs_pkg::PH_BLOCK, bbs_pkg::PH_VBR: begin
				if (scan_phase == bbs_pkg::PH_BLOCK) begin
					if (scan_offset > 32'd4 && d == bbs_pkg::MAGIC_WORD)
						return halt_scan(bbs_pkg::RSN_MAGIC, scan_offset, r);
					vbr_zero = 1'b1;
				end
				scan_offset = scan_offset + 32'd4;
				ended = 1'b0;
				for (k = 0; k < 8; k++) begin
					if (!ended) begin
						nib = d[4*k +: 4];
						if (nib[2:0] != 3'b000)
							vbr_zero = 1'b0;
						if (!nib[3])
							ended = 1'b1;
					end
				end
				if (ended) begin
					if (vbr_zero)
						return halt_scan(bbs_pkg::RSN_ZERO_VBR, scan_offset, r);
					scan_phase = bbs_pkg::PH_LENGTH;
				end else begin
					scan_phase = bbs_pkg::PH_VBR;
				end
				return check_room(r);
			end
			bbs_pkg::PH_LENGTH: begin
				scan_offset = scan_offset + 32'd4;
				if (d == 32'd0)
					return halt_scan(bbs_pkg::RSN_ZERO_LEN, scan_offset, r);
				left = (scan_offset <= buf_bytes) ? {2'b00, buf_bytes - scan_offset} : '0;
				if ({d, 2'b00} > left)
					return halt_scan(bbs_pkg::RSN_LEN_BIG, scan_offset, r);
				skip_left  = d;
				scan_phase = bbs_pkg::PH_SKIP;
				return 1'b0;
			end
			bbs_pkg::PH_SKIP: begin
				scan_offset = scan_offset + 32'd4;
				if (skip_left != 32'd0)
					skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0) begin
					scan_phase = bbs_pkg::PH_BLOCK;
					return check_room(r);
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// receiver: checks each result and drives the stall
	initial begin
		int               wait_left;
		int               hold_left;
		int               hold_served;
		bbs_pkg::result_t want;
		result_stall = 1'b0;
		wait_left    = 0;
		hold_left    = 0;
		hold_served  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: used_bytes=%0d stop_reason=%0d",
							result.used_bytes, result.stop_reason);
				end else begin
					want = pending_results.pop_front();
					if (result.used_bytes !== want.used_bytes) begin
						errors++;
						if (errors <= 10)
							$display("used_bytes mismatch: expected %0d, got %0d",
								want.used_bytes, result.used_bytes);
					end
					if (result.stop_reason !== want.stop_reason) begin
						errors++;
						if (errors <= 10)
							$display("stop_reason mismatch: expected %0d, got %0d (used_bytes %0d)",
								want.stop_reason, result.stop_reason, want.used_bytes);
					end
				end
				wait_left = calm ? 0 : $urandom_range(0, 8);
			end
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [31:0] d, input logic first);
		int               gap;
		bit               hit;
		bbs_pkg::result_t r;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) word_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		word_valid       <= 1'b1;
		word.data_word   <= d;
		word.first_word  <= first;
		do @(posedge clk); while (word_stall);
		// transfer taken at this edge
		if (!first && (scan_phase == bbs_pkg::PH_IDLE || scan_phase == bbs_pkg::PH_DONE))
			words_ignored++;
		else
			words_active++;
		hit = scan_word(d, first, r);
		if (hit)
			pending_results.push_back(r);
	endtask

	// words after a stop are mostly dropped, now and then sent as noise
	task automatic emit(input logic [31:0] d, input logic first);
		if (first || scan_phase != bbs_pkg::PH_DONE || $urandom_range(0, 15) == 0)
			send_word(d, first);
	endtask

	// wait for every result, then let the block drain
	task automatic settle();
		@(negedge clk) word_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_buffer_bytes(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		buf_bytes = v;
		settings_used++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// last VBR word: a chunk without continue bit at a random position
	function automatic logic [31:0] vbr_tail(input bit zero);
		logic [31:0] w;
		int          k;
		int          i;
		w = $urandom;
		k = $urandom_range(0, 7);
		for (i = 0; i < k; i++)
			w[4*i+3] = 1'b1;
		w[4*k+3] = 1'b0;
		if (zero)
			for (i = 0; i <= k; i++)
				w[4*i +: 3] = 3'b000;
		return w;
	endfunction

	task automatic send_buffer();
		int          nblk;
		int          ncont;
		int          pick;
		bit          zero;
		logic [31:0] len;
		logic [32:0] room;
		if ($urandom_range(0, 15) == 0) begin
			// not bitcode, with some trailing words
			emit($urandom, 1'b1);
			repeat ($urandom_range(0, 3)) emit($urandom, 1'b0);
			return;
		end
		emit(bbs_pkg::MAGIC_WORD, 1'b1);
		nblk = $urandom_range(1, 5);
		repeat (nblk) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				emit(bbs_pkg::MAGIC_WORD, 1'b0);
			else if (pick < 8)
				emit(bbs_pkg::MAGIC_WORD, 1'b1);
			zero  = ($urandom_range(0, 99) < 8);
			ncont = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (ncont)
				emit(zero ? 32'h8888_8888 : ($urandom | 32'h8888_8888), 1'b0);
			emit(vbr_tail(zero), 1'b0);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				len = 32'd0;
			end else if (pick < 16) begin
				len = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
			end else begin
				len = $urandom_range(1, 6);
				if (pick < 26) begin
					// right at the edge of what still fits
					room = ({1'b0, scan_offset} + 33'd4 <= {1'b0, buf_bytes}) ?
						{1'b0, buf_bytes} - {1'b0, scan_offset} - 33'd4 : '0;
					if ((room >> 2) <= 33'd40)
						len = 32'(room >> 2) + $urandom_range(0, 1);
				end
			end
			emit(len, 1'b0);
			if (len <= 32'd64)
				repeat (len) emit($urandom, 1'b0);
		end
	endtask

	task automatic test_directed();
		send_word(32'h1234_5678, 1'b0);      // before any first word
		send_word(32'hFFFF_FFFF, 1'b1);      // not bitcode
		send_word(bbs_pkg::MAGIC_WORD, 1'b1); // reset length: ends at once
		settle();
		set_buffer_bytes(32'd0);
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		settle();
		set_buffer_bytes(32'd3);
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		settle();
		set_buffer_bytes(32'hFFFF_FFFF);
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		send_word(bbs_pkg::MAGIC_WORD, 1'b0); // magic right after header is a VBR
		send_word(32'd1, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(bbs_pkg::MAGIC_WORD, 1'b0); // magic at a block start
		send_word(32'h0000_0000, 1'b0);      // after stop
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		send_word(32'h0000_0000, 1'b0);      // zero VBR
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		send_word(32'h8888_8888, 1'b0);      // VBR running over several words
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0008, 1'b0);
		send_word(32'h0000_0000, 1'b0);      // zero length
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);      // length too big
		settle();
		set_buffer_bytes(32'd16);
		send_word(bbs_pkg::MAGIC_WORD, 1'b1);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_ABCD, 1'b0);      // buffer end after the skip
		settle();
	endtask

	task automatic test_backpressure();
		set_buffer_bytes(32'hFFFF_FFFF);
		calm = 1'b1;
		hold_requests++;
		repeat (30) send_buffer();
		settle();
		calm = 1'b0;
	endtask

	task automatic test_random_buffers();
		int          phase_no;
		logic [31:0] len;
		phase_no = 0;
		while (words_active < ITEM_TARGET) begin
			case (phase_no % 8)
				0: len = 32'hFFFF_FFFF;
				1: len = $urandom_range(4, 600);
				2: len = 32'd64;
				3: len = $urandom;
				4: len = $urandom_range(8, 48);
				5: len = 32'hFFFF_FFFC;
				6: len = $urandom_range(0, 7);
				default: len = 32'd4096;
			endcase
			settle();
			set_buffer_bytes(len);
			calm = (phase_no % 5 == 4);
			repeat (25) send_buffer();
			phase_no++;
		end
		settle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		word_valid    = 1'b0;
		word          = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		calm          = 1'b0;
		hold_requests = 0;
		words_active  = 0;
		words_ignored = 0;
		results_seen  = 0;
		settings_used = 0;
		errors        = 0;
		scan_phase    = bbs_pkg::PH_IDLE;
		scan_offset   = '0;
		skip_left     = '0;
		vbr_zero      = 1'b1;
		buf_bytes     = 32'd4;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_random_buffers();

		$display("scanned %0d words (%0d more dropped after stops), checked %0d results",
			words_active, words_ignored, results_seen);
		$display("covered %0d buffer length settings and a %0d-cycle result hold",
			settings_used, HOLD_CYCLES);
		if (errors == 0)
			$display("bitcode_block_size_scanner_test: PASS");
		else
			$display("bitcode_block_size_scanner_test: FAIL");
		$finish;
	end

endmodule

### bitcode_block_size_scanner.f
design/bbs_pkg.sv
design/bbs_front.sv
design/bbs_queue.sv
design/bbs_back.sv
design/bitcode_block_size_scanner.sv
verif/bitcode_block_size_scanner_test.sv
